// ----- hdl/scps_pkg.sv -----
// Package for the sorted category pair set: state type, command codes, list kinds and control/status structs.
// Used by the controller, the datapath and the top level. No dependencies.
package scps_pkg;

	localparam logic [1:0] CMD_QUERY  = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] KIND_PAIR  = 2'd0;
	localparam logic [1:0] KIND_BEGIN = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEN,
		ST_SRCH,
		ST_SWAIT,
		ST_CHECK,
		ST_SHIFT,
		ST_SHWAIT,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic len_rd;
		logic srch_rd;
		logic srch_upd;
		logic check;
		logic shift_rd;
		logic shift_wr;
		logic final_wr;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic clear_done;
		logic invalid;
		logic srch_done;
		logic do_shift;
		logic shift_done;
		logic do_write;
	} stat_t;

endpackage

// ----- hdl/scps_ctrl.sv -----
// Controller state machine for the sorted category pair set.
// Depends on scps_pkg.
module scps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_free,
	input  scps_pkg::stat_t stat,
	output logic           in_ready,
	output scps_pkg::ctrl_t ctrl
);
	import scps_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR:  if (stat.clear_done) state_nx = ST_IDLE;
			ST_IDLE:   if (in_valid) state_nx = ST_LEN;
			ST_LEN:    state_nx = stat.invalid ? ST_DONE : ST_SRCH;
			ST_SRCH:   state_nx = stat.srch_done ? ST_CHECK : ST_SWAIT;
			ST_SWAIT:  state_nx = ST_SRCH;
			ST_CHECK:  state_nx = ST_SHIFT;
			ST_SHIFT: begin
				if (stat.do_shift && !stat.shift_done) state_nx = ST_SHWAIT;
				else if (stat.do_write) state_nx = ST_WRITE;
				else state_nx = ST_DONE;
			end
			ST_SHWAIT: state_nx = ST_SHIFT;
			ST_WRITE:  state_nx = ST_DONE;
			ST_DONE:   if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR:  ctrl.clear = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				ctrl.load = in_valid;
			end
			ST_LEN:    ctrl.len_rd = 1'b1;
			ST_SRCH:   ctrl.srch_rd = !stat.srch_done;
			ST_SWAIT:  ctrl.srch_upd = 1'b1;
			ST_CHECK:  ctrl.check = 1'b1;
			ST_SHIFT:  ctrl.shift_rd = stat.do_shift && !stat.shift_done;
			ST_SHWAIT: ctrl.shift_wr = 1'b1;
			ST_WRITE:  ctrl.final_wr = 1'b1;
			ST_DONE:   ctrl.out_load = out_free;
			default:   ctrl = '0;
		endcase
	end

endmodule

// ----- hdl/scps_dp.sv -----
// Datapath for the sorted category pair set: entry memory, length table and search/shift.
// Depends on scps_pkg; driven by scps_ctrl.
module scps_dp #(
	parameter int NUM_CATEGORIES = 256,
	parameter int LIST_CAPACITY  = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  scps_pkg::ctrl_t ctrl,
	input  logic [1:0]      cmd,
	input  logic [1:0]      list_kind,
	input  logic [7:0]      row_cat,
	input  logic [7:0]      key_cat,
	output scps_pkg::stat_t stat,
	output logic            res_present,
	output logic            res_status,
	output logic [6:0]      res_length
);
	import scps_pkg::*;

	localparam int NumLists = NUM_CATEGORIES + 2;
	localparam int SelW = $clog2(NumLists);
	localparam int PosW = $clog2(LIST_CAPACITY);
	localparam int LenW = $clog2(LIST_CAPACITY + 1);
	localparam int AddrW = SelW + PosW;
	localparam int RowW = (SelW > 8) ? SelW : 9;

	logic [7:0]      mem [NumLists * (2 ** PosW)];
	logic [LenW-1:0] len_mem [NumLists];

	logic [1:0]       cmd_q;
	logic [7:0]       key_q;
	logic [SelW-1:0]  sel_q;
	logic [SelW-1:0]  clr_q;
	logic             inv_q;
	logic [LenW-1:0]  len_q, lo_q, hi_q, sh_q;
	logic             eq_q, hit_q, full_q, add_q, rem_q;
	logic [7:0]       rd_q;
	logic [LenW-1:0]  mid;
	logic [LenW-1:0]  len_out;
	logic             hit_now;
	logic [AddrW-1:0] rd_addr;
	logic             rd_en;

	always_comb begin
		mid = LenW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (ctrl.srch_rd) begin
			rd_en = 1'b1;
			rd_addr = {sel_q, mid[PosW-1:0]};
		end else if (ctrl.shift_rd) begin
			rd_en = 1'b1;
			if (cmd_q == CMD_ADD) rd_addr = {sel_q, PosW'(sh_q - LenW'(1))};
			else rd_addr = {sel_q, PosW'(sh_q + LenW'(1))};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[rd_addr];
		if (ctrl.shift_wr) mem[{sel_q, sh_q[PosW-1:0]}] <= rd_q;
		else if (ctrl.final_wr) mem[{sel_q, lo_q[PosW-1:0]}] <= key_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) len_mem[clr_q] <= '0;
		else if (ctrl.out_load && !inv_q) len_mem[sel_q] <= len_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (ctrl.clear) clr_q <= clr_q + SelW'(1);
	end

	assign hit_now = (lo_q != len_q) && eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd;
			key_q <= key_cat;
			unique case (list_kind)
				KIND_PAIR: begin
					inv_q <= (RowW'(row_cat) >= RowW'(NUM_CATEGORIES));
					sel_q <= SelW'(row_cat);
				end
				KIND_BEGIN: begin
					inv_q <= 1'b0;
					sel_q <= SelW'(NUM_CATEGORIES);
				end
				KIND_END: begin
					inv_q <= 1'b0;
					sel_q <= SelW'(NUM_CATEGORIES + 1);
				end
				default: begin
					inv_q <= 1'b1;
					sel_q <= '0;
				end
			endcase
		end
		if (ctrl.len_rd) begin
			len_q <= len_mem[sel_q];
			hi_q <= len_mem[sel_q];
			lo_q <= '0;
			eq_q <= 1'b0;
		end
		if (ctrl.srch_upd) begin
			if (rd_q < key_q) lo_q <= mid + LenW'(1);
			else begin
				hi_q <= mid;
				eq_q <= (rd_q == key_q);
			end
		end
		if (ctrl.check) begin
			hit_q <= hit_now;
			add_q <= (cmd_q == CMD_ADD) && !hit_now && (len_q != LenW'(LIST_CAPACITY));
			full_q <= (cmd_q == CMD_ADD) && !hit_now && (len_q == LenW'(LIST_CAPACITY));
			rem_q <= (cmd_q == CMD_REMOVE) && hit_now;
			if (cmd_q == CMD_ADD) sh_q <= len_q;
			else sh_q <= lo_q;
		end
		if (ctrl.shift_wr) begin
			if (cmd_q == CMD_ADD) sh_q <= sh_q - LenW'(1);
			else sh_q <= sh_q + LenW'(1);
		end
		if (ctrl.final_wr) len_q <= len_q + LenW'(1);
	end

	assign len_out = rem_q ? len_q - LenW'(1) : len_q;

	assign stat.clear_done = (clr_q == SelW'(NumLists - 1));
	assign stat.invalid = inv_q;
	assign stat.srch_done = (lo_q == hi_q);
	assign stat.do_shift = rem_q || add_q;
	assign stat.shift_done = rem_q ? ((sh_q + LenW'(1)) >= len_q) : (sh_q == lo_q);
	assign stat.do_write = add_q;

	assign res_present = hit_q && !inv_q;
	assign res_status = full_q && !inv_q;
	assign res_length = inv_q ? 7'd0 : 7'(len_out);

endmodule

// ----- hdl/sorted_category_pair_set.sv -----
// Top level of the sorted category pair set: controller, datapath and output register.
// Depends on scps_pkg, scps_ctrl and scps_dp.
//
//  channel | signals                                   | dir
//  in      | in_valid in_ready cmd list_kind row_cat key_cat | into block
//  out     | out_valid out_ready was_present status new_length | out of block
//
// From acceptance to the next acceptance a word passes through a length read, a binary
// search over the list, a check, the shift of the moved entries and, for an insert, a final
// write. The single-port entry memory gives each search step and each moved entry a read
// state followed by a second state (SWAIT, SHWAIT) that updates the bounds or writes.
// After reset a clearing pass zeroes all NUM_CATEGORIES + 2 entries of the length table.
// A new word is taken while the previous result waits in the output register.
module sorted_category_pair_set #(
	parameter int NUM_CATEGORIES = 256,
	parameter int LIST_CAPACITY  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [1:0] list_kind,
	input  logic [7:0] row_cat,
	input  logic [7:0] key_cat,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       was_present,
	output logic       status,
	output logic [6:0] new_length
);
	import scps_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic res_present, res_status;
	logic [6:0] res_length;
	logic out_free;

	assign out_free = !out_valid || out_ready;

	scps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .out_free(out_free),
		.stat(stat), .in_ready(in_ready), .ctrl(ctrl)
	);

	scps_dp #(.NUM_CATEGORIES(NUM_CATEGORIES), .LIST_CAPACITY(LIST_CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .cmd(cmd), .list_kind(list_kind),
		.row_cat(row_cat), .key_cat(key_cat), .stat(stat),
		.res_present(res_present), .res_status(res_status), .res_length(res_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (ctrl.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			was_present <= res_present;
			status <= res_status;
			new_length <= res_length;
		end
	end

	a_status_add: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load && res_status |-> !res_present)
		else $error("full flag with key present");
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load && (LIST_CAPACITY < 128) |-> res_length <= 7'(LIST_CAPACITY))
		else $error("length beyond capacity");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> !ctrl.out_load)
		else $error("result without work");

endmodule
